// File: rtl/core/tgm_pkg.sv
// Package for the timed gate motor controller: field widths, register indexes,
// phase and command codes, and the constant reciprocal used for ms-to-seconds.
// No dependencies.
package tgm_pkg;

  localparam int DUTY_BITS_DEF   = 10;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int TIME_W  = 32;
  localparam int SEC_W   = 23;   // now_ms / 1000 tops out at 4294967
  localparam int TRAV_W  = 8;
  localparam int THR_W   = 12;
  localparam int TOUT_W  = 16;
  localparam int DREG_W  = 10;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;
  localparam int CMP_W   = 16;   // common width for sample against threshold

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam int unsigned MS_PER_S    = 1000;
  localparam int          RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;
  localparam int          PROD_W      = TIME_W + RECIP_W;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_OPEN_TRAVEL  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_CLOSE_TRAVEL = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CLOSE_DELAY  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_STALL_THR    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_STALL_TOUT   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DRIVE_DUTY   = 3'd5;

  // reported motor phase
  localparam logic [1:0] PHASE_CLOSE = 2'd0;
  localparam logic [1:0] PHASE_OPEN  = 2'd1;
  localparam logic [1:0] PHASE_IDLE  = 2'd2;

  // latched command
  localparam logic [1:0] CMD_CLOSE = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_NONE  = 2'd2;

endpackage

// File: rtl/core/timed_gate_motor_with_stall_stop.sv
// Timed gate motor controller with stall stop: top level and only module.
// Depends on tgm_pkg.
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------------
//  input     in_valid / in_ready    mode, now_ms, current_sample
//  result    out_valid / out_ready  drive_a, drive_b, select_line, duty, moving,
//                                   phase, stall_stop
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
// One transaction per cycle sustained while the result channel is not stalled.
// Stage A registers the call, stage B turns now_ms into seconds with one
// reciprocal multiply, stage C does the compares and updates the controller state.
// Each stage advances when the one after it is empty or moving, so a stalled
// result holds only the stages that are full behind it.
// Synchronous active-high reset clears all valid bits and the controller state
// and loads the register defaults.
module timed_gate_motor_with_stall_stop #(
  parameter int DUTY_BITS   = tgm_pkg::DUTY_BITS_DEF,
  parameter int SAMPLE_BITS = tgm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       mode,
  input  logic [tgm_pkg::TIME_W-1:0] now_ms,
  input  logic [SAMPLE_BITS-1:0]     current_sample,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       drive_a,
  output logic                       drive_b,
  output logic                       select_line,
  output logic [DUTY_BITS-1:0]       duty,
  output logic                       moving,
  output logic [1:0]                 phase,
  output logic                       stall_stop,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tgm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [tgm_pkg::CDATA_W-1:0] cfg_data
);

  localparam int SEC_W  = tgm_pkg::SEC_W;
  localparam int TIME_W = tgm_pkg::TIME_W;
  localparam int CMP_W  = tgm_pkg::CMP_W;

  // ---------------- configuration registers ----------------
  logic [tgm_pkg::TRAV_W-1:0] open_travel_s;
  logic [tgm_pkg::TRAV_W-1:0] close_travel_s;
  logic [tgm_pkg::TRAV_W-1:0] close_delay_s;
  logic [tgm_pkg::THR_W-1:0]  stall_threshold;
  logic [tgm_pkg::TOUT_W-1:0] stall_timeout_ms;
  logic [tgm_pkg::DREG_W-1:0] drive_duty;

  assign cfg_ready = 1'b1;

  // the user must write only while the pipeline is empty (the block does not enforce this); unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      open_travel_s    <= 8'd5;
      close_travel_s   <= 8'd5;
      close_delay_s    <= 8'd0;
      stall_threshold  <= 12'd4095;
      stall_timeout_ms <= 16'd500;
      drive_duty       <= 10'd1023;
    end else if (cfg_valid) begin
      case (cfg_index)
        tgm_pkg::REG_OPEN_TRAVEL:  open_travel_s    <= cfg_data[tgm_pkg::TRAV_W-1:0];
        tgm_pkg::REG_CLOSE_TRAVEL: close_travel_s   <= cfg_data[tgm_pkg::TRAV_W-1:0];
        tgm_pkg::REG_CLOSE_DELAY:  close_delay_s    <= cfg_data[tgm_pkg::TRAV_W-1:0];
        tgm_pkg::REG_STALL_THR:    stall_threshold  <= cfg_data[tgm_pkg::THR_W-1:0];
        tgm_pkg::REG_STALL_TOUT:   stall_timeout_ms <= cfg_data[tgm_pkg::TOUT_W-1:0];
        tgm_pkg::REG_DRIVE_DUTY:   drive_duty       <= cfg_data[tgm_pkg::DREG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic a_v, b_v;
  logic en_a, en_b, en_c;

  assign en_c     = !out_valid || out_ready;
  assign en_b     = !b_v || en_c;
  assign en_a     = !a_v || en_b;
  assign in_ready = en_a;

  // ---------------- stage A: registered call ----------------
  logic                   a_mode;
  logic [TIME_W-1:0]      a_now;
  logic [SAMPLE_BITS-1:0] a_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en_a) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_mode   <= mode;
      a_now    <= now_ms;
      a_sample <= current_sample;
    end
  end

  // ---------------- stage B: milliseconds to seconds ----------------
  logic [tgm_pkg::PROD_W-1:0] prod;
  logic                       b_mode;
  logic [TIME_W-1:0]          b_now;
  logic [SAMPLE_BITS-1:0]     b_sample;
  logic [SEC_W-1:0]           b_now_s;

  assign prod = tgm_pkg::PROD_W'(a_now) * tgm_pkg::PROD_W'(tgm_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en_b) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_v) begin
      b_mode   <= a_mode;
      b_now    <= a_now;
      b_sample <= a_sample;
      b_now_s  <= prod[tgm_pkg::RECIP_SHIFT +: SEC_W];
    end
  end

  // ---------------- stage C: controller ----------------
  logic [1:0]        cmd, cmd_next;
  logic [SEC_W-1:0]  start_second, start_second_next;
  logic              travel_done, travel_done_next;
  logic              stall_timing, stall_timing_next;
  logic [TIME_W-1:0] stall_start, stall_start_next;
  logic              sel_level, sel_level_next;

  logic              new_cmd;
  logic [SEC_W:0]    diff;        // extra bit flags a backwards timestamp
  logic              late;        // set when the timestamp went backwards
  logic [SEC_W-1:0]  elapsed;
  logic [SEC_W-1:0]  after_delay;
  logic [CMP_W-1:0]  sample_w, thr_w;
  logic              over_thr;
  logic [TIME_W-1:0] stall_ms;

  logic              o_a, o_b, o_drive, o_stall, o_moving;
  logic [1:0]        o_phase;

  always_comb begin
    new_cmd = ({1'b0, b_mode} != cmd);
    if (new_cmd) begin
      diff = '0;
    end else begin
      diff = {1'b0, b_now_s} - {1'b0, start_second};
    end
    late        = diff[SEC_W];
    elapsed     = diff[SEC_W-1:0];
    after_delay = elapsed - SEC_W'(close_delay_s);
    sample_w    = CMP_W'(b_sample);
    thr_w       = CMP_W'(stall_threshold) & CMP_W'((32'd1 << SAMPLE_BITS) - 32'd1);
    over_thr    = (sample_w >= thr_w);
    stall_ms    = b_now - stall_start;

    cmd_next          = cmd;
    start_second_next = start_second;
    travel_done_next  = travel_done;
    stall_timing_next = stall_timing;
    stall_start_next  = stall_start;
    sel_level_next    = sel_level;
    o_a      = 1'b0;
    o_b      = 1'b0;
    o_drive  = 1'b0;
    o_stall  = 1'b0;
    o_moving = 1'b0;
    o_phase  = tgm_pkg::PHASE_IDLE;

    if (new_cmd) begin
      cmd_next          = {1'b0, b_mode};
      start_second_next = b_now_s;
      travel_done_next  = 1'b0;
      stall_timing_next = 1'b0;
    end

    if (travel_done_next) begin
      // stays stopped until the command changes
    end else if (b_mode) begin
      if (!late && (elapsed < SEC_W'(open_travel_s))) begin
        sel_level_next = 1'b1;
        o_a      = 1'b1;
        o_drive  = 1'b1;
        o_moving = 1'b1;
        o_phase  = tgm_pkg::PHASE_OPEN;
      end else begin
        travel_done_next  = 1'b1;
        stall_timing_next = 1'b0;
      end
    end else if (!late && (elapsed < SEC_W'(close_delay_s))) begin
      // waiting out the close delay with the bridge off
    end else if (!late && (after_delay < SEC_W'(close_travel_s))) begin
      if (over_thr && stall_timing_next &&
          (stall_ms >= TIME_W'(stall_timeout_ms))) begin
        sel_level_next    = 1'b1;
        travel_done_next  = 1'b1;
        stall_timing_next = 1'b0;
        o_stall           = 1'b1;
      end else begin
        if (over_thr) begin
          if (!stall_timing_next) begin
            stall_timing_next = 1'b1;
            stall_start_next  = b_now;
          end
        end else begin
          stall_timing_next = 1'b0;
        end
        sel_level_next = 1'b0;
        o_b      = 1'b1;
        o_drive  = 1'b1;
        o_moving = 1'b1;
        o_phase  = tgm_pkg::PHASE_CLOSE;
      end
    end else begin
      travel_done_next  = 1'b1;
      stall_timing_next = 1'b0;
    end
  end

  logic fire_c;
  assign fire_c = en_c && b_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd          <= tgm_pkg::CMD_NONE;
      start_second <= '0;
      travel_done  <= 1'b0;
      stall_timing <= 1'b0;
      stall_start  <= '0;
      sel_level    <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (en_c) begin
        out_valid <= b_v;
      end
      if (fire_c) begin
        cmd          <= cmd_next;
        start_second <= start_second_next;
        travel_done  <= travel_done_next;
        stall_timing <= stall_timing_next;
        stall_start  <= stall_start_next;
        sel_level    <= sel_level_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire_c) begin
      drive_a     <= o_a;
      drive_b     <= o_b;
      select_line <= sel_level_next;
      duty        <= o_drive ? DUTY_BITS'(drive_duty) : '0;
      moving      <= o_moving;
      phase       <= o_phase;
      stall_stop  <= o_stall;
    end
  end

`ifndef SYNTHESIS
  // the bridge is never driven both ways at once
  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_a && drive_b))
    else $error("both bridge inputs driven");

  // a stall stop leaves the motor stopped with the select line high
  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stall_stop) |-> (!moving && select_line && phase == tgm_pkg::PHASE_IDLE))
    else $error("stall stop with motor still driven");

  // once stopped, a repeat of the same command stays stopped
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (fire_c && travel_done && !new_cmd) |=> (!moving && phase == tgm_pkg::PHASE_IDLE))
    else $error("motor restarted without a command change");

  // an accepted transaction is held in stage A
  a_capture: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> a_v)
    else $error("accepted transaction lost");
`endif

endmodule
